// ===== hdl/assert_macros.svh =====
// assertion macros used by the flattener core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// expression that must never hold outside reset
`define ASSERT_NEVER_CLK(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error(msg);

`endif

// ===== hdl/baf_pkg.sv =====
// shared constants, types and functions of the bezier flattener
`default_nettype none

package baf_pkg;

	// coordinate and internal word formats
	localparam int COORD_W  = 24;
	localparam int EXT_BITS = 6;
	localparam int WORD_W   = 32;
	localparam int PAD_W    = WORD_W - COORD_W - EXT_BITS;
	localparam int TERM_W   = WORD_W + 2;
	localparam int ACC_W    = WORD_W + 4;
	localparam int Q_W      = WORD_W + 1 - EXT_BITS;

	// threshold register
	localparam int THR_W = 26;
	localparam logic [THR_W-1:0] THR_RESET = 26'd256;

	// subdivision depth limit
	localparam int DEF_MAX_DEPTH = 6;

	// reciprocal of three: floor(x/3) = (x * THIRD_MUL) >> THIRD_SHIFT for x < 2^31
	localparam int MUL_W       = 30;
	localparam int THIRD_SHIFT = 31;
	localparam logic [MUL_W-1:0] THIRD_MUL = 30'h2AAA_AAAB;

	// shared unit operations
	localparam logic [1:0] ALU_MID    = 2'd0;
	localparam logic [1:0] ALU_TERM   = 2'd1;
	localparam logic [1:0] ALU_THIRD  = 2'd2;
	localparam logic [1:0] ALU_ADDSUB = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic       neg;
	} alu_ctl_t;

	// coordinate to internal word with extra fraction bits
	function automatic logic [WORD_W-1:0] to_word(input logic [COORD_W-1:0] c);
		return {{PAD_W{c[COORD_W-1]}}, c, {EXT_BITS{1'b0}}};
	endfunction

	// internal word to coordinate: round half up, then saturate
	function automatic logic [COORD_W-1:0] to_coord(input logic [WORD_W-1:0] w);
		logic signed [WORD_W:0] r;
		logic signed [Q_W-1:0]  q;
		logic [COORD_W-1:0]     res;
		r = $signed({w[WORD_W-1], w}) + $signed({{(WORD_W+1-EXT_BITS){1'b0}},
			1'b1, {(EXT_BITS-1){1'b0}}});
		q = r[WORD_W:EXT_BITS];
		if (q > $signed({{(Q_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}})) begin
			res = {1'b0, {(COORD_W-1){1'b1}}};
		end else if (q < $signed({{(Q_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}})) begin
			res = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			res = q[COORD_W-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/baf_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module baf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/baf_alu.sv =====
// shared arithmetic unit: midpoint, second difference, third, add/sub
`default_nettype none

module baf_alu import baf_pkg::*; (
	input  wire alu_ctl_t          ctl,
	input  wire logic [WORD_W-1:0] a,
	input  wire logic [WORD_W-1:0] b,
	input  wire logic [WORD_W-1:0] c,
	output logic      [TERM_W-1:0] res
);

	logic signed [WORD_W:0]       mid_sum;
	logic signed [TERM_W-1:0]     diff;
	logic [TERM_W-1:0]            diff_abs;
	logic [WORD_W-1:0]            mag;
	logic [WORD_W+MUL_W-1:0]      prod;
	logic [WORD_W-1:0]            third;
	logic [WORD_W-1:0]            addsub;

	// midpoint, floor of (a+b)/2
	assign mid_sum = $signed({a[WORD_W-1], a}) + $signed({b[WORD_W-1], b});

	// second difference a + c - 2b and its magnitude
	assign diff = $signed({{2{a[WORD_W-1]}}, a}) + $signed({{2{c[WORD_W-1]}}, c})
		- $signed({b[WORD_W-1], b, 1'b0});
	assign diff_abs = diff[TERM_W-1] ? (~diff + TERM_W'(1)) : diff;

	// rounded third of |a|, by reciprocal multiply
	assign mag   = (a[WORD_W-1] ? (~a + WORD_W'(1)) : a) + WORD_W'(1);
	assign prod  = mag * THIRD_MUL;
	assign third = WORD_W'(prod >> THIRD_SHIFT);

	// add or subtract
	assign addsub = ctl.neg ? (a - b) : (a + b);

	// result select
	always_comb begin
		case (ctl.op)
			ALU_MID:    res = {{2{mid_sum[WORD_W]}}, mid_sum[WORD_W:1]};
			ALU_TERM:   res = diff_abs;
			ALU_THIRD:  res = {2'b00, third};
			ALU_ADDSUB: res = {2'b00, addsub};
			default:    res = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/bezier_adaptive_flattener_core.sv =====
// adaptive cubic bezier flattener top level
//
// channel | direction | handshake          | payload
// cfg     | in        | psel/penable/pready | paddr, pwdata, prdata (flatness_threshold)
// in      | in        | in_valid/in_stall   | start, end, tangents, linear
// out     | out       | out_valid/out_stall | point_x, point_y, depth_capped, last
//
// one segment at a time; in_stall is high from acceptance until the last point is handed
// to the output register. the control points are loaded first; each split node then runs
// curviness, decide, midpoint and push steps and each leaf runs curviness, decide, emit
// and, unless it is the last, pop steps, all through the one shared arithmetic unit.
// out_stall holds the sequencer at emit. arst_n clears control state only; the subdivision
// stack ram needs no clearing.
`default_nettype none
`include "assert_macros.svh"

module bezier_adaptive_flattener_core import baf_pkg::*; #(
	parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	// segment input
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [COORD_W-1:0] start_x,
	input  wire logic [COORD_W-1:0] start_y,
	input  wire logic [COORD_W-1:0] start_dir_x,
	input  wire logic [COORD_W-1:0] start_dir_y,
	input  wire logic [COORD_W-1:0] end_x,
	input  wire logic [COORD_W-1:0] end_y,
	input  wire logic [COORD_W-1:0] end_dir_x,
	input  wire logic [COORD_W-1:0] end_dir_y,
	input  wire logic               linear,
	// point output
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic      [COORD_W-1:0] point_x,
	output logic      [COORD_W-1:0] point_y,
	output logic                    depth_capped,
	output logic                    last
);

	localparam int LW    = $clog2(MAX_DEPTH + 1);
	localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int ROW_W = LW + 8 * WORD_W;

	localparam logic REG_FLATNESS_THRESHOLD = 1'b0;

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_LOAD   = 3'd1;
	localparam logic [2:0] S_CURV   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_SPLIT  = 3'd4;
	localparam logic [2:0] S_PUSH   = 3'd5;
	localparam logic [2:0] S_EMIT   = 3'd6;
	localparam logic [2:0] S_POP    = 3'd7;

	logic [2:0]         state_q;
	logic [3:0]         step_q;
	logic [LW-1:0]      level_q;
	logic [LW-1:0]      sd_q;
	logic [THR_W-1:0]   thr_q;

	logic [WORD_W-1:0]  cx_q  [4];
	logic [WORD_W-1:0]  cy_q  [4];
	logic [WORD_W-1:0]  rx_q  [4];
	logic [WORD_W-1:0]  ry_q  [4];
	logic [WORD_W-1:0]  dir_q [4];
	logic [WORD_W-1:0]  third_q;
	logic               third_neg_q;
	logic [ACC_W-1:0]   acc_q;
	logic               over_q;

	logic               out_valid_q;
	logic [COORD_W-1:0] point_x_q;
	logic [COORD_W-1:0] point_y_q;
	logic               capped_q;
	logic               last_q;

	logic               in_go;
	logic               emit_go;
	logic               cfg_wr;
	logic               over_c;
	logic               split_ok;
	logic               sel_y;
	logic [2:0]         split_sub;
	logic [WORD_W-1:0]  wc [4];
	logic [WORD_W-1:0]  wr [4];
	logic [1:0]         load_k;

	alu_ctl_t           alu_ctl;
	logic [WORD_W-1:0]  alu_a;
	logic [WORD_W-1:0]  alu_b;
	logic [WORD_W-1:0]  alu_c;
	logic [TERM_W-1:0]  alu_res;
	logic [WORD_W-1:0]  alu_word;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ROW_W-1:0]   ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [ROW_W-1:0]   ram_rdata;
	logic [LW-1:0]      sd_dec;
	logic [LW-1:0]      level_inc;

	// handshakes
	assign in_go    = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign emit_go  = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign cfg_wr   = psel && penable && pwrite && pready;

	// configuration read side
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FLATNESS_THRESHOLD) ? {{(32-THR_W){1'b0}}, thr_q} : '0;

	// split decision
	assign over_c   = acc_q > {{(ACC_W-THR_W-EXT_BITS){1'b0}}, thr_q, {EXT_BITS{1'b0}}};
	assign split_ok = over_c && (level_q < LW'(MAX_DEPTH)) && (sd_q < LW'(MAX_DEPTH));

	// axis and sub-step selection
	assign sel_y     = (state_q == S_CURV) ? step_q[0] : (step_q >= 4'd6);
	assign split_sub = (step_q >= 4'd6) ? 3'(step_q - 4'd6) : step_q[2:0];
	assign load_k    = step_q[2:1];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			wc[i] = sel_y ? cy_q[i] : cx_q[i];
			wr[i] = sel_y ? ry_q[i] : rx_q[i];
		end
	end

	// operand selection for the shared unit
	always_comb begin
		alu_ctl = '{op: ALU_MID, neg: 1'b0};
		alu_a   = '0;
		alu_b   = '0;
		alu_c   = '0;
		case (state_q)
			S_LOAD: begin
				if (!step_q[0]) begin
					alu_ctl.op = ALU_THIRD;
					alu_a      = dir_q[load_k];
				end else begin
					alu_ctl.op  = ALU_ADDSUB;
					alu_ctl.neg = third_neg_q ^ load_k[1];
					alu_b       = third_q;
					case (load_k)
						2'd0:    alu_a = cx_q[0];
						2'd1:    alu_a = cy_q[0];
						2'd2:    alu_a = cx_q[3];
						default: alu_a = cy_q[3];
					endcase
				end
			end
			S_CURV: begin
				alu_ctl.op = ALU_TERM;
				alu_a      = step_q[1] ? wc[1] : wc[0];
				alu_b      = step_q[1] ? wc[2] : wc[1];
				alu_c      = step_q[1] ? wc[3] : wc[2];
			end
			S_SPLIT: begin
				alu_ctl.op = ALU_MID;
				case (split_sub)
					3'd0: begin alu_a = wc[2]; alu_b = wc[3]; end
					3'd1: begin alu_a = wc[1]; alu_b = wc[2]; end
					3'd2: begin alu_a = wc[0]; alu_b = wc[1]; end
					3'd3: begin alu_a = wc[1]; alu_b = wr[1]; end
					3'd4: begin alu_a = wr[1]; alu_b = wr[2]; end
					default: begin alu_a = wc[2]; alu_b = wr[1]; end
				endcase
			end
			default: begin
				alu_ctl = '{op: ALU_MID, neg: 1'b0};
			end
		endcase
	end

	baf_alu u_alu (
		.ctl (alu_ctl),
		.a   (alu_a),
		.b   (alu_b),
		.c   (alu_c),
		.res (alu_res)
	);

	assign alu_word = alu_res[WORD_W-1:0];

	// stack of right halves
	assign sd_dec    = sd_q - LW'(1);
	assign level_inc = level_q + LW'(1);
	assign ram_we    = (state_q == S_PUSH);
	assign ram_waddr = sd_q[AW-1:0];
	assign ram_re    = emit_go && (sd_q != '0);
	assign ram_raddr = sd_dec[AW-1:0];

	always_comb begin
		ram_wdata = '0;
		ram_wdata[8*WORD_W +: LW] = level_inc;
		for (int i = 0; i < 4; i++) begin
			ram_wdata[(4+i)*WORD_W +: WORD_W] = rx_q[i];
			ram_wdata[i*WORD_W +: WORD_W]     = ry_q[i];
		end
	end

	baf_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAX_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			level_q     <= '0;
			sd_q        <= '0;
			thr_q       <= THR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr && (paddr[2] == REG_FLATNESS_THRESHOLD)) begin
				thr_q <= pwdata[THR_W-1:0];
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_go) begin
						state_q <= S_LOAD;
						step_q  <= '0;
						level_q <= '0;
						sd_q    <= '0;
					end
				end
				S_LOAD: begin
					if (step_q == 4'd7) begin
						state_q <= S_CURV;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_CURV: begin
					if (step_q == 4'd3) begin
						state_q <= S_DECIDE;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_DECIDE: begin
					state_q <= split_ok ? S_SPLIT : S_EMIT;
					step_q  <= '0;
				end
				S_SPLIT: begin
					if (step_q == 4'd11) begin
						state_q <= S_PUSH;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_PUSH: begin
					level_q <= level_inc;
					sd_q    <= sd_q + LW'(1);
					state_q <= S_CURV;
				end
				S_EMIT: begin
					if (emit_go) begin
						if (sd_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							sd_q    <= sd_dec;
							state_q <= S_POP;
						end
					end
				end
				S_POP: begin
					level_q <= ram_rdata[8*WORD_W +: LW];
					state_q <= S_CURV;
					step_q  <= '0;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_go) begin
					cx_q[0]  <= to_word(start_x);
					cy_q[0]  <= to_word(start_y);
					cx_q[3]  <= to_word(end_x);
					cy_q[3]  <= to_word(end_y);
					dir_q[0] <= linear ? '0 : to_word(start_dir_x);
					dir_q[1] <= linear ? '0 : to_word(start_dir_y);
					dir_q[2] <= linear ? '0 : to_word(end_dir_x);
					dir_q[3] <= linear ? '0 : to_word(end_dir_y);
				end
			end
			S_LOAD: begin
				if (!step_q[0]) begin
					third_q     <= alu_word;
					third_neg_q <= dir_q[load_k][WORD_W-1];
				end else begin
					case (load_k)
						2'd0:    cx_q[1] <= alu_word;
						2'd1:    cy_q[1] <= alu_word;
						2'd2:    cx_q[2] <= alu_word;
						default: cy_q[2] <= alu_word;
					endcase
				end
			end
			S_CURV: begin
				acc_q <= ((step_q == 4'd0) ? '0 : acc_q) + ACC_W'(alu_res);
			end
			S_DECIDE: begin
				over_q <= over_c;
			end
			S_SPLIT: begin
				// in-place de casteljau halving, one midpoint per cycle
				if (sel_y) begin
					case (split_sub)
						3'd0: begin ry_q[2] <= alu_word; ry_q[3] <= cy_q[3]; end
						3'd1: ry_q[1] <= alu_word;
						3'd2: cy_q[1] <= alu_word;
						3'd3: cy_q[2] <= alu_word;
						3'd4: ry_q[1] <= alu_word;
						default: begin cy_q[3] <= alu_word; ry_q[0] <= alu_word; end
					endcase
				end else begin
					case (split_sub)
						3'd0: begin rx_q[2] <= alu_word; rx_q[3] <= cx_q[3]; end
						3'd1: rx_q[1] <= alu_word;
						3'd2: cx_q[1] <= alu_word;
						3'd3: cx_q[2] <= alu_word;
						3'd4: rx_q[1] <= alu_word;
						default: begin cx_q[3] <= alu_word; rx_q[0] <= alu_word; end
					endcase
				end
			end
			S_EMIT: begin
				if (emit_go) begin
					point_x_q <= to_coord(cx_q[3]);
					point_y_q <= to_coord(cy_q[3]);
					capped_q  <= over_q;
					last_q    <= (sd_q == '0);
				end
			end
			S_POP: begin
				for (int i = 0; i < 4; i++) begin
					cx_q[i] <= ram_rdata[(4+i)*WORD_W +: WORD_W];
					cy_q[i] <= ram_rdata[i*WORD_W +: WORD_W];
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// output register
	assign out_valid    = out_valid_q;
	assign point_x      = point_x_q;
	assign point_y      = point_y_q;
	assign depth_capped = capped_q;
	assign last         = last_q;

	// checks
	`ASSERT_NEVER_CLK(a_stack_le_level, sd_q > level_q, "stack deeper than curve level")
	`ASSERT_CLK(a_push_room, (state_q == S_PUSH) |-> (sd_q < LW'(MAX_DEPTH)), "push on full stack")
	`ASSERT_CLK(a_cap_at_limit, (emit_go && over_q) |-> (level_q == LW'(MAX_DEPTH)), "capped point below depth limit")

endmodule

`default_nettype wire

// ===== dv/baf_point_checker.sv =====
// point checker for the bezier flattener: predicts polyline points and compares
`timescale 1ns / 100ps

module baf_point_checker import baf_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	input  wire logic [31:0]        prdata,
	input  wire logic               pready,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic [COORD_W-1:0] start_x,
	input  wire logic [COORD_W-1:0] start_y,
	input  wire logic [COORD_W-1:0] start_dir_x,
	input  wire logic [COORD_W-1:0] start_dir_y,
	input  wire logic [COORD_W-1:0] end_x,
	input  wire logic [COORD_W-1:0] end_y,
	input  wire logic [COORD_W-1:0] end_dir_x,
	input  wire logic [COORD_W-1:0] end_dir_y,
	input  wire logic               linear,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic [COORD_W-1:0] point_x,
	input  wire logic [COORD_W-1:0] point_y,
	input  wire logic               depth_capped,
	input  wire logic               last,
	output int                      fail_count,
	output int                      points_pending
);

	localparam logic [2:0] THRESHOLD_ADDR = 3'd0;
	localparam int MAX_LEVEL = DEF_MAX_DEPTH;
	localparam int MAX_LEAVES = 1 << MAX_LEVEL;
	localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
	localparam longint COORD_MIN = -(longint'(1) << (COORD_W - 1));

	typedef struct {
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic               capped;
		logic               last;
	} flat_point_t;

	flat_point_t       predicted_points[$];
	logic [THR_W-1:0]  flat_limit = THR_RESET;

	initial begin
		fail_count = 0;
		points_pending = 0;
	end

	// tangent over three, nearest
	function automatic longint third_nearest(input longint v);
		if (v >= 0) begin
			return (v + 1) / 3;
		end
		return -((-v + 1) / 3);
	endfunction

	// midpoint, rounded toward minus infinity
	function automatic longint mid_floor(input longint a, input longint b);
		return (a + b) >>> 1;
	endfunction

	function automatic longint mag(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// internal word back to a coordinate: half up, then clamp
	function automatic logic [COORD_W-1:0] round_to_coord(input longint v);
		longint q;
		q = (v + (longint'(1) << (EXT_BITS - 1))) >>> EXT_BITS;
		if (q > COORD_MAX) begin
			q = COORD_MAX;
		end else if (q < COORD_MIN) begin
			q = COORD_MIN;
		end
		return q[COORD_W-1:0];
	endfunction

	// l1 of the two second differences along one axis
	function automatic longint axis_bend(input int p[4]);
		longint a, b, c, d;
		a = p[0];
		b = p[1];
		c = p[2];
		d = p[3];
		return mag(a + c - 2 * b) + mag(b + d - 2 * c);
	endfunction

	// de casteljau halving: left half is o[0..3], right half o[3..6]
	function automatic void halve(input int p[4], output longint o[7]);
		longint l1, m, r2, l2, r1;
		l1 = mid_floor(p[0], p[1]);
		m = mid_floor(p[1], p[2]);
		r2 = mid_floor(p[2], p[3]);
		l2 = mid_floor(l1, m);
		r1 = mid_floor(m, r2);
		o[0] = p[0];
		o[1] = l1;
		o[2] = l2;
		o[3] = mid_floor(l2, r1);
		o[4] = r1;
		o[5] = r2;
		o[6] = p[3];
	endfunction

	// depth-first flattening of one hermite segment into predicted points
	function automatic void flatten_segment(input logic [COORD_W-1:0] f[8], input logic lin,
		input logic [THR_W-1:0] limit);
		longint      v[8];
		longint      lx[7], ly[7];
		longint      thr;
		int          cur_x[4], cur_y[4];
		int          stk_x[4*MAX_LEVEL], stk_y[4*MAX_LEVEL];
		int          stk_lvl[MAX_LEVEL];
		int          sp, lvl, n;
		bit          over;
		flat_point_t pt;
		for (int i = 0; i < 8; i++) begin
			v[i] = longint'($signed(f[i])) <<< EXT_BITS;
		end
		if (lin) begin
			v[2] = 0;
			v[3] = 0;
			v[6] = 0;
			v[7] = 0;
		end
		cur_x[0] = int'(v[0]);
		cur_y[0] = int'(v[1]);
		cur_x[1] = int'(v[0] + third_nearest(v[2]));
		cur_y[1] = int'(v[1] + third_nearest(v[3]));
		cur_x[2] = int'(v[4] - third_nearest(v[6]));
		cur_y[2] = int'(v[5] - third_nearest(v[7]));
		cur_x[3] = int'(v[4]);
		cur_y[3] = int'(v[5]);
		thr = longint'(limit) << EXT_BITS;
		sp = 0;
		lvl = 0;
		n = 0;
		while (1) begin
			over = (axis_bend(cur_x) + axis_bend(cur_y)) > thr;
			if (over && lvl < MAX_LEVEL && sp < MAX_LEVEL) begin
				// split: keep left half, push right half
				halve(cur_x, lx);
				halve(cur_y, ly);
				for (int i = 0; i < 4; i++) begin
					stk_x[sp*4+i] = int'(lx[3+i]);
					stk_y[sp*4+i] = int'(ly[3+i]);
					cur_x[i] = int'(lx[i]);
					cur_y[i] = int'(ly[i]);
				end
				lvl++;
				stk_lvl[sp] = lvl;
				sp++;
			end else begin
				if (n >= MAX_LEAVES) begin
					break;
				end
				// leaf: emit its end point, then pop
				pt.px = round_to_coord(longint'(cur_x[3]));
				pt.py = round_to_coord(longint'(cur_y[3]));
				pt.capped = over;
				pt.last = (sp == 0);
				predicted_points.push_back(pt);
				n++;
				if (sp == 0) begin
					break;
				end
				sp--;
				for (int i = 0; i < 4; i++) begin
					cur_x[i] = stk_x[sp*4+i];
					cur_y[i] = stk_y[sp*4+i];
				end
				lvl = stk_lvl[sp];
			end
		end
	endfunction

	// channel monitor
	always @(posedge clk or negedge arst_n) begin
		flat_point_t        want;
		logic [COORD_W-1:0] seg[8];
		if (!arst_n) begin
			flat_limit = THR_RESET;
			predicted_points.delete();
		end else begin
			// register transactions
			if (psel && penable && pready && pwrite && paddr == THRESHOLD_ADDR) begin
				flat_limit = pwdata[THR_W-1:0];
			end
			if (psel && penable && pready && !pwrite && paddr == THRESHOLD_ADDR) begin
				if (prdata !== {{(32-THR_W){1'b0}}, flat_limit}) begin
					$error("prdata: expected %0d, got %0d", flat_limit, prdata);
					fail_count++;
				end
			end
			// output transaction against the oldest prediction
			if (out_valid && !out_stall) begin
				if (predicted_points.size() == 0) begin
					$error("point with nothing predicted: point_x %0d point_y %0d",
						$signed(point_x), $signed(point_y));
					fail_count++;
				end else begin
					want = predicted_points.pop_front();
					if (point_x !== want.px) begin
						$error("point_x: expected %0d, got %0d", $signed(want.px),
							$signed(point_x));
						fail_count++;
					end
					if (point_y !== want.py) begin
						$error("point_y: expected %0d, got %0d", $signed(want.py),
							$signed(point_y));
						fail_count++;
					end
					if (depth_capped !== want.capped) begin
						$error("depth_capped: expected %0d, got %0d", want.capped,
							depth_capped);
						fail_count++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						fail_count++;
					end
				end
			end
			// input transaction
			if (in_valid && !in_stall) begin
				seg[0] = start_x;
				seg[1] = start_y;
				seg[2] = start_dir_x;
				seg[3] = start_dir_y;
				seg[4] = end_x;
				seg[5] = end_y;
				seg[6] = end_dir_x;
				seg[7] = end_dir_y;
				flatten_segment(seg, linear, flat_limit);
			end
		end
		points_pending = predicted_points.size();
	end

endmodule

// ===== dv/tb_bezier_adaptive_flattener_core.sv =====
// testbench top for the bezier flattener: stimulus, idling and verdict
`timescale 1ns / 100ps

module tb_bezier_adaptive_flattener_core;
	import baf_pkg::*;

	localparam logic [2:0] THRESHOLD_ADDR = 3'd0;
	localparam logic [2:0] UNMAPPED_ADDR = 3'd4;
	localparam logic [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic [COORD_W-1:0] C_ZERO = '0;
	localparam int HOLD_CYCLES = 600;
	localparam int QUIET_LIMIT = 8000;
	localparam int SETTLE_CYCLES = 10;
	localparam int DRAIN_CYCLES = 200;
	localparam int ITEMS_PER_SETTING = 24;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [COORD_W-1:0] start_x = '0;
	logic [COORD_W-1:0] start_y = '0;
	logic [COORD_W-1:0] start_dir_x = '0;
	logic [COORD_W-1:0] start_dir_y = '0;
	logic [COORD_W-1:0] end_x = '0;
	logic [COORD_W-1:0] end_y = '0;
	logic [COORD_W-1:0] end_dir_x = '0;
	logic [COORD_W-1:0] end_dir_y = '0;
	logic               linear = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [COORD_W-1:0] point_x;
	logic [COORD_W-1:0] point_y;
	logic               depth_capped;
	logic               last;
	int                 fail_count;
	int                 points_pending;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;

	bezier_adaptive_flattener_core uut (.*);

	baf_point_checker point_check (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver side: random stall plus the occasional long hold-off
	initial begin
		int holds_seen;
		int hold_left;
		holds_seen = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (holds_seen != hold_requests) begin
				holds_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_idle_pct);
			if (hold_left > 0) begin
				hold_left--;
			end
		end
	end

	// watchdog: ends the run when nothing moves for too long
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("bezier_adaptive_flattener_core: mismatch");
		$finish;
	end

	// one register transaction, setup then access, then psel dropped back to idle
	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// one segment transaction with an optional gap in front
	task automatic send_segment(input logic [COORD_W-1:0] sx, sy, sdx, sdy, ex, ey, edx, edy,
		input logic lin);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		start_x <= sx;
		start_y <= sy;
		start_dir_x <= sdx;
		start_dir_y <= sdy;
		end_x <= ex;
		end_y <= ey;
		end_dir_x <= edx;
		end_dir_y <= edy;
		linear <= lin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// random coordinate, scaled down to vary how curved segments get
	function automatic logic [COORD_W-1:0] rand_coord(input int shift);
		logic signed [COORD_W-1:0] r;
		r = COORD_W'($urandom);
		return r >>> shift;
	endfunction

	task automatic send_random_segment();
		int pos_shift;
		int dir_shift;
		if ($urandom_range(0, 5) == 0) begin
			pos_shift = 0;
			dir_shift = 0;
		end else begin
			pos_shift = $urandom_range(0, COORD_W - 1);
			dir_shift = $urandom_range(0, COORD_W - 1);
		end
		send_segment(rand_coord(pos_shift), rand_coord(pos_shift), rand_coord(dir_shift),
			rand_coord(dir_shift), rand_coord(pos_shift), rand_coord(pos_shift),
			rand_coord(dir_shift), rand_coord(dir_shift), $urandom_range(0, 7) == 0);
	endtask

	// drop valid and let every predicted point come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (points_pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [31:0] value);
		wait_idle();
		apb_access(1'b1, THRESHOLD_ADDR, value);
		apb_access(1'b0, THRESHOLD_ADDR, '0);
	endtask

	// stimulus
	initial begin
		logic [31:0] thr_plan[6];
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		thr_plan[0] = 32'h0000_0040;
		thr_plan[1] = 32'hFC00_0000;
		thr_plan[2] = 32'hFFFF_FFFF;
		thr_plan[3] = $urandom_range(0, 4096);
		thr_plan[4] = 32'd1;
		thr_plan[5] = $urandom;

		send_idle_pct = 18;
		recv_idle_pct = 73;

		// directed, reset threshold
		apb_access(1'b0, THRESHOLD_ADDR, '0);
		send_segment(C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0);
		send_segment(-24'sd8, 24'sd8, C_MAX, C_MIN, 24'sd8, -24'sd8, C_MAX, C_MIN, 1'b1);
		send_segment(-24'sd8, 24'sd8, C_MAX, C_MIN, 24'sd8, -24'sd8, C_MAX, C_MIN, 1'b0);
		// control points beyond the coordinate range: clamped points
		send_segment(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, 1'b0);
		send_segment(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, 1'b0);
		// curviness exactly at the threshold, then just above it
		send_segment(C_ZERO, C_ZERO, 24'sd384, C_ZERO, C_ZERO, C_ZERO, -24'sd384, C_ZERO, 1'b0);
		send_segment(C_ZERO, C_ZERO, 24'sd385, C_ZERO, C_ZERO, C_ZERO, -24'sd385, C_ZERO, 1'b0);
		// small tangents: thirds rounded both ways
		send_segment(24'sd1, -24'sd1, 24'sd1, -24'sd1, -24'sd2, 24'sd2, 24'sd2, -24'sd2, 1'b0);
		send_segment(C_MIN, C_MAX, C_ZERO, C_ZERO, C_MAX, C_MIN, C_ZERO, C_ZERO, 1'b0);
		send_segment(C_ZERO, C_ZERO, C_MAX, C_ZERO, C_ZERO, C_ZERO, C_MAX, C_ZERO, 1'b0);
		send_segment(24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
			24'hAAAAAA, 24'h555555, 1'b0);

		// write to an unmapped address must leave the threshold alone
		wait_idle();
		apb_access(1'b1, UNMAPPED_ADDR, 32'h0000_0001);
		apb_access(1'b0, THRESHOLD_ADDR, '0);
		send_segment(C_ZERO, C_ZERO, 24'sd385, C_ZERO, C_ZERO, C_ZERO, -24'sd385, C_ZERO, 1'b0);

		// largest threshold: nothing splits
		write_threshold(32'hFFFF_FFFF);
		send_segment(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, 1'b0);
		send_segment(-24'sd8, 24'sd8, C_MAX, C_MIN, 24'sd8, -24'sd8, C_MAX, C_MIN, 1'b0);

		// zero threshold: only a perfectly flat curve stays whole
		write_threshold(32'd0);
		send_segment(C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0);
		send_segment(24'sd1, -24'sd1, 24'sd1, -24'sd1, -24'sd2, 24'sd2, 24'sd2, -24'sd2, 1'b0);

		// random segments over a series of thresholds and idling patterns
		for (int k = 0; k < 6; k++) begin
			write_threshold(thr_plan[k]);
			if (k < 2) begin
				send_idle_pct = 18;
				recv_idle_pct = 73;
			end else if (k < 4) begin
				send_idle_pct = 73;
				recv_idle_pct = 18;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (k == 0 || k == 4) begin
				hold_requests++;
			end
			repeat (ITEMS_PER_SETTING) send_random_segment();
		end

		// drain and verdict
		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("bezier_adaptive_flattener_core: match");
		end else begin
			$display("bezier_adaptive_flattener_core: mismatch");
		end
		$finish;
	end

endmodule
